[hw/rtl/atess_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator package
// Shared types, fixed-point constants and helper functions.
// ----------------------------------------------------------------------------
package atess_pkg;

  localparam int MAX_SEGS_DEF = 62;
  localparam int SEG_W        = 6;
  localparam int ANG_W        = 36;
  localparam int ACC_W        = 40;
  localparam int CORDIC_LAST  = 27;

  localparam logic signed [ANG_W-1:0] ANG_PI          = 36'sd843314857;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI      = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI     = 36'sd421657428;
  localparam logic signed [ACC_W-1:0] CORDIC_GAIN_INV = 40'sd652032874;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] xaxis_x;
    logic signed [31:0] xaxis_y;
    logic signed [31:0] xaxis_z;
    logic signed [31:0] yaxis_x;
    logic signed [31:0] yaxis_y;
    logic signed [31:0] yaxis_z;
    logic        [30:0] radius;
    logic signed [31:0] start_angle;
    logic signed [31:0] end_angle;
  } arc_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic               last_point;
  } point_item_t;

  typedef struct packed {
    logic [30:0] max_deviation;
    logic [5:0]  min_segments;
    logic [31:0] tangent_step;
  } atess_cfg_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_LOAD, CMD_DIVC_INIT, CMD_DIV_STEP, CMD_SQ_MUL, CMD_SQ_INIT,
    CMD_SQ_STEP, CMD_VEC_INIT, CMD_VEC_STEP, CMD_SEG_SAT, CMD_DIVS_INIT,
    CMD_SEG_SET, CMD_COUNT, CMD_DIVU_INIT, CMD_PT_INIT, CMD_PT_U2,
    CMD_E_MUL_HI, CMD_E_MUL_LO, CMD_E_ANG, CMD_E_RED, CMD_ROT_STEP,
    CMD_E_MUL_RC, CMD_E_MUL_RS, CMD_E_AXIS, CMD_E_STORE, CMD_EMIT
  } atess_cmd_t;

  typedef struct packed {
    logic need_acos;
    logic theta_pos;
    logic ang_ok;
    logic cnt_div_last;
    logic cnt_sq_last;
    logic cnt_cor_last;
    logic cnt_ax_last;
    logic second;
    logic last_pt;
  } atess_stat_t;

  // arctangent of 2^-i in Q0.28
  function automatic logic [27:0] atan_step(input logic [4:0] i);
    logic [27:0] v;
    case (i)
      5'd0:    v = 28'd210828714;
      5'd1:    v = 28'd124459457;
      5'd2:    v = 28'd65760959;
      5'd3:    v = 28'd33381290;
      5'd4:    v = 28'd16755422;
      5'd5:    v = 28'd8385879;
      5'd6:    v = 28'd4193963;
      5'd7:    v = 28'd2097109;
      5'd8:    v = 28'd1048571;
      5'd9:    v = 28'd524287;
      5'd10:   v = 28'd262144;
      default: v = 28'd1 << (5'd28 - i);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/atess_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator channels
// Valid/ready channels for arc requests and point requests.
// ----------------------------------------------------------------------------
interface atess_arc_if import atess_pkg::*; ();
  logic      valid;
  logic      ready;
  arc_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface atess_pt_if import atess_pkg::*; ();
  logic        valid;
  logic        ready;
  point_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/atess_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator datapath
// Shared divider, square root, CORDIC and multiplier, run by commands.
// ----------------------------------------------------------------------------
module atess_dp import atess_pkg::*; #(
  parameter int MAX_SEGS = MAX_SEGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  atess_cmd_t  cmd,
  input  atess_cfg_t  cfg,
  input  arc_item_t   in_data,
  output atess_stat_t st,
  output point_item_t out_data
);

  logic signed [31:0] ctr [3];
  logic signed [31:0] xa [3];
  logic signed [31:0] ya [3];
  logic [30:0]        r;
  logic signed [31:0] a0;
  logic signed [32:0] da;
  logic [32:0]        dabs;

  logic [63:0] dvd;
  logic [32:0] dvs;
  logic [33:0] rem;
  logic [63:0] sv, res, sbit;

  logic signed [ACC_W-1:0] vx, vy;
  logic signed [ANG_W-1:0] vz;
  logic                    neg;

  logic [SEG_W-1:0] segs, n, ur, racc, idx;
  logic [32:0]      uq, u;
  logic signed [34:0] u2;
  logic             second;

  logic signed [67:0] prod, t1;
  logic signed [ANG_W-1:0] ang;
  logic signed [33:0] rc, rsv;
  logic signed [ACC_W-1:0] acc [3];
  logic signed [31:0] pp [3];
  logic signed [31:0] qq [3];
  logic [5:0] cnt;

  // combinational helpers
  logic [33:0] rem_sh;
  logic        div_ge;
  logic [63:0] sq_sum;
  logic signed [ACC_W-1:0] dx, dy, cs, sn;
  logic signed [ANG_W-1:0] atv;
  logic signed [33:0] ma, mb;
  logic signed [34:0] ue;
  logic signed [67:0] ang_sum, ang_shift, rnd;
  logic [6:0] n0a, n0b, n0c, racc_sum;
  logic [33:0] u2_lim;
  logic [5:0]  cnt_m1;
  logic [1:0]  ax_k;
  logic signed [ACC_W-1:0] diff [3];

  function automatic logic signed [67:0] round30(input logic signed [67:0] p);
    return (p + 68'sd536870912) >>> 30;
  endfunction

  always_comb begin
    rem_sh  = {rem[32:0], dvd[63]};
    div_ge  = rem_sh >= {1'b0, dvs};
    sq_sum  = res + sbit;
    dx      = vy >>> cnt[4:0];
    dy      = vx >>> cnt[4:0];
    atv     = $signed({8'd0, atan_step(cnt[4:0])});
    cs      = neg ? -vx : vx;
    sn      = neg ? -vy : vy;
    ue      = second ? u2 : $signed({2'b00, u});
    ang_sum   = t1 + (prod >>> 16);
    ang_shift = ang_sum >>> 16;
    rnd     = round30(prod);
    n0a     = (cfg.min_segments > segs) ? {1'b0, cfg.min_segments} : {1'b0, segs};
    n0b     = (n0a > 7'(MAX_SEGS)) ? 7'(MAX_SEGS) : n0a;
    n0c     = n0b[0] ? n0b + 7'd1 : n0b;
    racc_sum = {1'b0, racc} + {1'b0, ur};
    u2_lim  = 34'h1_0000_0000 - {2'b00, cfg.tangent_step};
    cnt_m1  = cnt - 6'd1;
    ax_k    = cnt_m1[2:1];
    for (int k = 0; k < 3; k++) begin
      diff[k] = ACC_W'(qq[k]) - ACC_W'(pp[k]);
    end
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd)
      CMD_SQ_MUL: begin
        ma = {3'd0, dvd[30:0]};
        mb = {3'd0, dvd[30:0]};
      end
      CMD_E_MUL_HI: begin
        ma = 34'(da);
        mb = 34'($signed(ue[34:16]));
      end
      CMD_E_MUL_LO: begin
        ma = 34'(da);
        mb = {18'd0, ue[15:0]};
      end
      CMD_E_MUL_RC: begin
        ma = {3'd0, r};
        mb = cs[33:0];
      end
      CMD_E_MUL_RS: begin
        ma = {3'd0, r};
        mb = sn[33:0];
      end
      CMD_E_AXIS: begin
        case (cnt)
          6'd0: begin ma = 34'(xa[0]); mb = rc; end
          6'd1: begin ma = 34'(ya[0]); mb = rsv; end
          6'd2: begin ma = 34'(xa[1]); mb = rc; end
          6'd3: begin ma = 34'(ya[1]); mb = rsv; end
          6'd4: begin ma = 34'(xa[2]); mb = rc; end
          6'd5: begin ma = 34'(ya[2]); mb = rsv; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    unique case (cmd)
      CMD_LOAD: begin
        ctr[0] <= in_data.center_x;
        ctr[1] <= in_data.center_y;
        ctr[2] <= in_data.center_z;
        xa[0]  <= in_data.xaxis_x;
        xa[1]  <= in_data.xaxis_y;
        xa[2]  <= in_data.xaxis_z;
        ya[0]  <= in_data.yaxis_x;
        ya[1]  <= in_data.yaxis_y;
        ya[2]  <= in_data.yaxis_z;
        r      <= in_data.radius;
        a0     <= in_data.start_angle;
        da     <= 33'(in_data.end_angle) - 33'(in_data.start_angle);
        dabs   <= (33'(in_data.end_angle) < 33'(in_data.start_angle)) ?
                  33'(33'(in_data.start_angle) - 33'(in_data.end_angle)) :
                  33'(33'(in_data.end_angle) - 33'(in_data.start_angle));
        segs   <= '0;
        second <= 1'b0;
      end
      CMD_DIVC_INIT: begin
        dvd <= {3'd0, r - cfg.max_deviation, 30'd0};
        dvs <= {2'b00, r};
        rem <= '0;
        cnt <= '0;
      end
      CMD_DIVS_INIT: begin
        dvd <= 64'({1'b0, dabs} + {2'b00, vz[31:0]});
        dvs <= {vz[31:0], 1'b0};
        rem <= '0;
        cnt <= '0;
      end
      CMD_DIVU_INIT: begin
        dvd <= 64'd1 << 32;
        dvs <= 33'(n);
        rem <= '0;
        cnt <= '0;
      end
      CMD_DIV_STEP: begin
        rem <= div_ge ? rem_sh - {1'b0, dvs} : rem_sh;
        dvd <= {dvd[62:0], div_ge};
        cnt <= cnt + 6'd1;
      end
      CMD_SQ_INIT: begin
        sv   <= (64'd1 << 60) - prod[63:0];
        res  <= '0;
        sbit <= 64'd1 << 62;
        cnt  <= '0;
      end
      CMD_SQ_STEP: begin
        if (sv >= sq_sum) begin
          sv  <= sv - sq_sum;
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
        cnt  <= cnt + 6'd1;
      end
      CMD_VEC_INIT: begin
        vx  <= $signed({9'd0, dvd[30:0]});
        vy  <= $signed(res[ACC_W-1:0]);
        vz  <= '0;
        cnt <= '0;
      end
      CMD_VEC_STEP: begin
        if (vy > 0) begin
          vx <= vx + dx;
          vy <= vy - dy;
          vz <= vz + atv;
        end else begin
          vx <= vx - dx;
          vy <= vy + dy;
          vz <= vz - atv;
        end
        cnt <= cnt + 6'd1;
      end
      CMD_SEG_SAT: segs <= SEG_W'(MAX_SEGS);
      CMD_SEG_SET: begin
        if ((|dvd[63:6]) || (dvd[5:0] > SEG_W'(MAX_SEGS))) begin
          segs <= SEG_W'(MAX_SEGS);
        end else begin
          segs <= dvd[5:0];
        end
      end
      CMD_COUNT: n <= (n0c < 7'd2) ? SEG_W'(2) : n0c[SEG_W-1:0];
      CMD_PT_INIT: begin
        uq   <= dvd[32:0];
        ur   <= rem[SEG_W-1:0];
        u    <= '0;
        racc <= '0;
        idx  <= '0;
      end
      CMD_PT_U2: begin
        if ({1'b0, u} < u2_lim) begin
          u2 <= $signed({2'b00, u} + {3'd0, cfg.tangent_step});
        end else begin
          u2 <= $signed({2'b00, u} - {3'd0, cfg.tangent_step});
        end
        second <= 1'b0;
      end
      CMD_E_MUL_LO: t1 <= prod;
      CMD_E_ANG: ang <= ANG_W'(a0) + ang_shift[ANG_W-1:0];
      CMD_E_RED: begin
        if (ang > ANG_PI) begin
          ang <= ang - ANG_TWO_PI;
        end else if (ang < -ANG_PI) begin
          ang <= ang + ANG_TWO_PI;
        end else begin
          if (ang > ANG_HALF_PI) begin
            vz  <= ang - ANG_PI;
            neg <= 1'b1;
          end else if (ang < -ANG_HALF_PI) begin
            vz  <= ang + ANG_PI;
            neg <= 1'b1;
          end else begin
            vz  <= ang;
            neg <= 1'b0;
          end
          vx  <= CORDIC_GAIN_INV;
          vy  <= '0;
          cnt <= '0;
        end
      end
      CMD_ROT_STEP: begin
        if (vz >= 0) begin
          vx <= vx - dx;
          vy <= vy + dy;
          vz <= vz - atv;
        end else begin
          vx <= vx + dx;
          vy <= vy - dy;
          vz <= vz + atv;
        end
        cnt <= cnt + 6'd1;
      end
      CMD_E_MUL_RC: begin
        for (int k = 0; k < 3; k++) begin
          acc[k] <= ACC_W'(ctr[k]);
        end
      end
      CMD_E_MUL_RS: begin
        rc  <= rnd[33:0];
        cnt <= '0;
      end
      CMD_E_AXIS: begin
        if (cnt == 6'd0) begin
          rsv <= rnd[33:0];
        end else begin
          acc[ax_k] <= acc[ax_k] + rnd[ACC_W-1:0];
        end
        cnt <= cnt + 6'd1;
      end
      CMD_E_STORE: begin
        for (int k = 0; k < 3; k++) begin
          if (second) begin
            qq[k] <= sat32(acc[k]);
          end else begin
            pp[k] <= sat32(acc[k]);
          end
        end
        second <= !second;
      end
      CMD_EMIT: begin
        out_data.point_x    <= pp[0];
        out_data.point_y    <= pp[1];
        out_data.point_z    <= pp[2];
        out_data.tangent_x  <= sat32(diff[0]);
        out_data.tangent_y  <= sat32(diff[1]);
        out_data.tangent_z  <= sat32(diff[2]);
        out_data.last_point <= (idx == n);
        if (racc_sum >= {1'b0, n}) begin
          racc <= SEG_W'(racc_sum - {1'b0, n});
          u    <= u + uq + 33'd1;
        end else begin
          racc <= racc_sum[SEG_W-1:0];
          u    <= u + uq;
        end
        idx <= idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st.need_acos    = cfg.max_deviation < r;
    st.theta_pos    = vz > 0;
    st.ang_ok       = (ang <= ANG_PI) && (ang >= -ANG_PI);
    st.cnt_div_last = cnt == 6'd63;
    st.cnt_sq_last  = cnt == 6'd31;
    st.cnt_cor_last = cnt == 6'(CORDIC_LAST);
    st.cnt_ax_last  = cnt == 6'd6;
    st.second       = second;
    st.last_pt      = idx == n;
  end

  a_count_even: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_COUNT |=> (n[0] == 1'b0 && n >= SEG_W'(2) && n <= SEG_W'(MAX_SEGS + 1)))
    else $error("segment count not even or out of range");

  a_frac_below_n: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_EMIT |-> (racc < n && idx <= n))
    else $error("parameter accumulator ran past segment count");

endmodule

[hw/rtl/atess_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator controller
// Sequences the datapath through count setup and per-point evaluation.
// ----------------------------------------------------------------------------
module atess_ctrl import atess_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  atess_stat_t st,
  output atess_cmd_t  cmd
);

  typedef enum logic [25:0] {
    S_IDLE   = 26'd1 << 0,
    S_CHECK  = 26'd1 << 1,
    S_DIVC   = 26'd1 << 2,
    S_SQMUL  = 26'd1 << 3,
    S_SQINIT = 26'd1 << 4,
    S_SQRT   = 26'd1 << 5,
    S_VINIT  = 26'd1 << 6,
    S_VEC    = 26'd1 << 7,
    S_SEGCHK = 26'd1 << 8,
    S_DIVS   = 26'd1 << 9,
    S_SEGSET = 26'd1 << 10,
    S_COUNT  = 26'd1 << 11,
    S_DIVUI  = 26'd1 << 12,
    S_DIVU   = 26'd1 << 13,
    S_PINIT  = 26'd1 << 14,
    S_PT     = 26'd1 << 15,
    S_EHI    = 26'd1 << 16,
    S_ELO    = 26'd1 << 17,
    S_EANG   = 26'd1 << 18,
    S_ERED   = 26'd1 << 19,
    S_ECOR   = 26'd1 << 20,
    S_ERC    = 26'd1 << 21,
    S_ERS    = 26'd1 << 22,
    S_EAX    = 26'd1 << 23,
    S_ESTORE = 26'd1 << 24,
    S_EMIT   = 26'd1 << 25
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = CMD_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.need_acos) begin
          cmd        = CMD_DIVC_INIT;
          state_next = S_DIVC;
        end else begin
          state_next = S_COUNT;
        end
      end
      S_DIVC: begin
        cmd = CMD_DIV_STEP;
        if (st.cnt_div_last) state_next = S_SQMUL;
      end
      S_SQMUL: begin
        cmd        = CMD_SQ_MUL;
        state_next = S_SQINIT;
      end
      S_SQINIT: begin
        cmd        = CMD_SQ_INIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd = CMD_SQ_STEP;
        if (st.cnt_sq_last) state_next = S_VINIT;
      end
      S_VINIT: begin
        cmd        = CMD_VEC_INIT;
        state_next = S_VEC;
      end
      S_VEC: begin
        cmd = CMD_VEC_STEP;
        if (st.cnt_cor_last) state_next = S_SEGCHK;
      end
      S_SEGCHK: begin
        if (st.theta_pos) begin
          cmd        = CMD_DIVS_INIT;
          state_next = S_DIVS;
        end else begin
          cmd        = CMD_SEG_SAT;
          state_next = S_COUNT;
        end
      end
      S_DIVS: begin
        cmd = CMD_DIV_STEP;
        if (st.cnt_div_last) state_next = S_SEGSET;
      end
      S_SEGSET: begin
        cmd        = CMD_SEG_SET;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd        = CMD_COUNT;
        state_next = S_DIVUI;
      end
      S_DIVUI: begin
        cmd        = CMD_DIVU_INIT;
        state_next = S_DIVU;
      end
      S_DIVU: begin
        cmd = CMD_DIV_STEP;
        if (st.cnt_div_last) state_next = S_PINIT;
      end
      S_PINIT: begin
        cmd        = CMD_PT_INIT;
        state_next = S_PT;
      end
      S_PT: begin
        cmd        = CMD_PT_U2;
        state_next = S_EHI;
      end
      S_EHI: begin
        cmd        = CMD_E_MUL_HI;
        state_next = S_ELO;
      end
      S_ELO: begin
        cmd        = CMD_E_MUL_LO;
        state_next = S_EANG;
      end
      S_EANG: begin
        cmd        = CMD_E_ANG;
        state_next = S_ERED;
      end
      S_ERED: begin
        cmd = CMD_E_RED;
        if (st.ang_ok) state_next = S_ECOR;
      end
      S_ECOR: begin
        cmd = CMD_ROT_STEP;
        if (st.cnt_cor_last) state_next = S_ERC;
      end
      S_ERC: begin
        cmd        = CMD_E_MUL_RC;
        state_next = S_ERS;
      end
      S_ERS: begin
        cmd        = CMD_E_MUL_RS;
        state_next = S_EAX;
      end
      S_EAX: begin
        cmd = CMD_E_AXIS;
        if (st.cnt_ax_last) state_next = S_ESTORE;
      end
      S_ESTORE: begin
        cmd        = CMD_E_STORE;
        state_next = st.second ? S_EMIT : S_EHI;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd        = CMD_EMIT;
          state_next = st.last_pt ? S_IDLE : S_PT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_EMIT |-> (!out_valid || out_ready))
    else $error("point register loaded while a request waits");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted arc did not start count setup");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_EMIT |=> out_valid)
    else $error("emitted point not presented");

endmodule

[hw/rtl/arc_tessellator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator
// Splits one 3D circular arc per request into evenly spaced points with
// finite-difference tangents.
// ----------------------------------------------------------------------------
// Usage:
//   arcs   : valid/ready sink, one arc (center, plane axes, radius, angles).
//   points : valid/ready source, n+1 point requests per arc, the final one
//            flagged by last_point.
//   APB    : max_deviation at 0x0, min_segments at 0x4, tangent_step at 0x8;
//            write only while no arc is in flight.
// Timing: one arc at a time. Count setup runs up to three 64-step divisions,
//   a 32-step square root and a 28-step CORDIC when the deviation is below
//   the radius, and one 64-step division otherwise. Each point then runs an
//   angle reduction until the angle lies within +-pi and the shared 28-step
//   rotation CORDIC, twice per point.
// Reset clears the sequencer and the output valid and restores the config
//   defaults (not the datapath). A stalled receiver holds the point register;
//   the block finishes the next point, then waits until the held one is taken.
// ----------------------------------------------------------------------------
module arc_tessellator import atess_pkg::*; #(
  parameter int MAX_SEGS = MAX_SEGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  atess_arc_if.sink         arcs,
  atess_pt_if.source        points,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    REG_MAX_DEV  = 2'd0,
    REG_MIN_SEGS = 2'd1,
    REG_TAN_STEP = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  atess_cfg_t  cfg;
  atess_cmd_t  cmd;
  atess_stat_t st;
  reg_idx_t    widx;
  logic        wr_en;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // register file: write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_deviation <= 31'd65536;
      cfg.min_segments  <= 6'd6;
      cfg.tangent_step  <= 32'd4295;
    end else if (wr_en) begin
      unique case (widx)
        REG_MAX_DEV:  cfg.max_deviation <= pwdata[30:0];
        REG_MIN_SEGS: cfg.min_segments  <= pwdata[5:0];
        REG_TAN_STEP: cfg.tangent_step  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_MAX_DEV:  prdata = {1'b0, cfg.max_deviation};
      REG_MIN_SEGS: prdata = {26'd0, cfg.min_segments};
      REG_TAN_STEP: prdata = cfg.tangent_step;
      default:      prdata = '0;
    endcase
  end

  // sequencer: owns the handshakes and the point valid flag
  atess_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (arcs.valid),
    .in_ready  (arcs.ready),
    .out_valid (points.valid),
    .out_ready (points.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // arithmetic: holds the arc, the count state and the point register
  atess_dp #(
    .MAX_SEGS (MAX_SEGS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (arcs.data),
    .st       (st),
    .out_data (points.data)
  );

endmodule
